// File: sv/kvst_pkg.sv
package kvst_pkg;

   // field widths of one request and one response beat
   localparam int FUNC_W  = 3;
   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int SLOT_W  = 6;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 7;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_SEARCH = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_REWIND = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_NEXT   = 3'd4;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
   localparam logic [STAT_W-1:0] STAT_EXHAUSTED = 2'd3;

   // one finished response from the engine
   typedef struct packed {
      logic [SLOT_W-1:0]  slot;
      logic [STAT_W-1:0]  status;
      logic [KEY_W-1:0]   key_out;
      logic [VALUE_W-1:0] value_out;
      logic [COUNT_W-1:0] live_count;
   } result_type;

endpackage

// File: sv/kvst_ram.sv
module kvst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/kvst_engine.sv
module kvst_engine #(
   parameter int CAPACITY = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   // request side
   input  logic                          start,
   output logic                          idle,
   input  logic [kvst_pkg::FUNC_W-1:0]   func,
   input  logic [kvst_pkg::KEY_W-1:0]    key,
   input  logic [kvst_pkg::VALUE_W-1:0]  value,
   // memory side
   output logic [$clog2(CAPACITY)-1:0]   rd_addr,
   input  logic [kvst_pkg::KEY_W:0]      key_rdata,
   input  logic [kvst_pkg::VALUE_W-1:0]  val_rdata,
   output logic [$clog2(CAPACITY)-1:0]   wr_addr,
   output logic                          key_we,
   output logic [kvst_pkg::KEY_W:0]      key_wdata,
   output logic                          val_we,
   output logic [kvst_pkg::VALUE_W-1:0]  val_wdata,
   // response side
   output logic                          res_valid,
   input  logic                          res_ready,
   output kvst_pkg::result_type          res
);
   import kvst_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_type;

   state_type          state_ff, state_in;
   logic [FUNC_W-1:0]  func_ff, func_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [CW-1:0]      addr_ff, addr_in;
   logic               chk_ff, chk_in;
   logic [AW-1:0]      chk_idx_ff, chk_idx_in;
   logic               hit_ff, hit_in;
   logic [AW-1:0]      hit_idx_ff, hit_idx_in;
   logic [KEY_W-1:0]   hit_key_ff, hit_key_in;
   logic [VALUE_W-1:0] hit_val_ff, hit_val_in;
   logic               free_found_ff, free_found_in;
   logic [AW-1:0]      free_idx_ff, free_idx_in;
   logic [CW-1:0]      hw_ff, hw_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [CW-1:0]      iter_ff, iter_in;

   logic               issue;
   logic               match;
   logic               fire;
   logic [AW-1:0]      slot_idx;
   logic [STAT_W-1:0]  res_status;
   logic [KEY_W-1:0]   res_key;
   logic [VALUE_W-1:0] res_value;
   logic [SLOT_W+AW-1:0]  slot_wide;
   logic [COUNT_W+CW-1:0] cnt_wide;

   assign idle    = (state_ff == S_IDLE);
   assign issue   = (state_ff == S_SCAN) && (addr_ff < hw_ff);
   assign rd_addr = addr_ff[AW-1:0];
   assign fire    = (state_ff == S_DONE) && res_ready;

   // compare stage: data of slot chk_idx_ff arrives this cycle
   assign match = chk_ff && key_rdata[KEY_W]
                  && ((func_ff == FUNC_NEXT) || (key_rdata[KEY_W-1:0] == key_ff));

   // sequencer and table bookkeeping
   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      addr_in       = addr_ff;
      chk_in        = chk_ff;
      chk_idx_in    = chk_idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_key_in    = hit_key_ff;
      hit_val_in    = hit_val_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      hw_in         = hw_ff;
      cnt_in        = cnt_ff;
      iter_in       = iter_ff;
      key_we        = 1'b0;
      val_we        = 1'b0;
      wr_addr       = hit_idx_ff;
      key_wdata     = {1'b1, key_ff};
      val_wdata     = value_ff;
      slot_idx      = '0;
      res_status    = STAT_OK;
      res_key       = '0;
      res_value     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               func_in       = func;
               key_in        = key;
               value_in      = value;
               chk_in        = 1'b0;
               hit_in        = 1'b0;
               free_found_in = 1'b0;
               state_in      = S_SCAN;
               // scan range starts here and ends at the high-water mark
               if (func == FUNC_NEXT) begin
                  addr_in = iter_ff;
               end else if (func == FUNC_INSERT || func == FUNC_REMOVE
                            || func == FUNC_SEARCH) begin
                  addr_in = '0;
               end else begin
                  addr_in = hw_ff;
               end
            end
         end
         S_SCAN: begin
            chk_in     = issue;
            chk_idx_in = addr_ff[AW-1:0];
            if (issue) begin
               addr_in = addr_ff + CW'(1);
            end
            // remember the first free slot for insert
            if (chk_ff && !key_rdata[KEY_W] && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = chk_idx_ff;
            end
            if (match) begin
               hit_in     = 1'b1;
               hit_idx_in = chk_idx_ff;
               hit_key_in = key_rdata[KEY_W-1:0];
               hit_val_in = val_rdata;
               state_in   = S_DONE;
            end else if (!issue) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            unique case (func_ff)
               FUNC_INSERT: begin
                  if (hit_ff) begin
                     slot_idx = hit_idx_ff;
                     val_we   = fire;
                  end else if (free_found_ff) begin
                     slot_idx = free_idx_ff;
                     wr_addr  = free_idx_ff;
                     key_we   = fire;
                     val_we   = fire;
                     cnt_in   = fire ? cnt_ff + CW'(1) : cnt_ff;
                  end else if (hw_ff < CW'(CAPACITY)) begin
                     slot_idx = hw_ff[AW-1:0];
                     wr_addr  = hw_ff[AW-1:0];
                     key_we   = fire;
                     val_we   = fire;
                     cnt_in   = fire ? cnt_ff + CW'(1) : cnt_ff;
                     hw_in    = fire ? hw_ff + CW'(1) : hw_ff;
                  end else begin
                     res_status = STAT_FULL;
                  end
               end
               FUNC_REMOVE: begin
                  if (hit_ff) begin
                     slot_idx  = hit_idx_ff;
                     key_wdata = {1'b0, key_ff};
                     key_we    = fire;
                     cnt_in    = fire ? cnt_ff - CW'(1) : cnt_ff;
                  end else begin
                     res_status = STAT_NOT_FOUND;
                  end
               end
               FUNC_SEARCH: begin
                  if (hit_ff) begin
                     slot_idx  = hit_idx_ff;
                     res_value = hit_val_ff;
                  end else begin
                     res_status = STAT_NOT_FOUND;
                  end
               end
               FUNC_REWIND: begin
                  iter_in = fire ? '0 : iter_ff;
               end
               FUNC_NEXT: begin
                  if (hit_ff) begin
                     slot_idx  = hit_idx_ff;
                     res_key   = hit_key_ff;
                     res_value = hit_val_ff;
                     iter_in   = fire ? CW'(hit_idx_ff) + CW'(1) : iter_ff;
                  end else begin
                     res_status = STAT_EXHAUSTED;
                     iter_in    = fire ? hw_ff : iter_ff;
                  end
               end
               default: begin
               end
            endcase
            if (fire) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response fields, masked to the port widths
   assign slot_wide = {{SLOT_W{1'b0}}, slot_idx};
   assign cnt_wide  = {{COUNT_W{1'b0}}, cnt_in};
   assign res       = {slot_wide[SLOT_W-1:0], res_status, res_key, res_value,
                       cnt_wide[COUNT_W-1:0]};
   assign res_valid = (state_ff == S_DONE);

   // state and registered bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         chk_ff        <= 1'b0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         hw_ff         <= '0;
         cnt_ff        <= '0;
         iter_ff       <= '0;
         addr_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         chk_ff        <= chk_in;
         hit_ff        <= hit_in;
         free_found_ff <= free_found_in;
         hw_ff         <= hw_in;
         cnt_ff        <= cnt_in;
         iter_ff       <= iter_in;
         addr_ff       <= addr_in;
      end
      func_ff     <= func_in;
      key_ff      <= key_in;
      value_ff    <= value_in;
      chk_idx_ff  <= chk_idx_in;
      hit_idx_ff  <= hit_idx_in;
      hit_key_ff  <= hit_key_in;
      hit_val_ff  <= hit_val_in;
      free_idx_ff <= free_idx_in;
   end

   // live entries never exceed the slots ever used
   assert property (@(posedge clock) disable iff (reset) cnt_ff <= hw_ff)
      else $error("live count above high-water mark");

   // high-water mark stays within capacity
   assert property (@(posedge clock) disable iff (reset) hw_ff <= CW'(CAPACITY))
      else $error("high-water mark above capacity");

   // iterator never runs past the high-water mark
   assert property (@(posedge clock) disable iff (reset) iter_ff <= hw_ff)
      else $error("iterator beyond high-water mark");

   // a successful remove drops the live count by one
   assert property (@(posedge clock) disable iff (reset)
      (fire && func_ff == FUNC_REMOVE && hit_ff) |=> cnt_ff == $past(cnt_ff) - CW'(1))
      else $error("remove did not decrement live count");

endmodule

// File: sv/key_value_slot_table_unit.sv
// Key/value slot table of CAPACITY entries searched linearly. Insert writes or overwrites a
// key, remove frees its slot, search returns its slot and value, and rewind/next walk the
// live slots in index order; every response carries the live count. Keys and values live
// in synchronous single-read-port memories; a live bit is stored beside each key. Slots at
// or above the high-water mark are never read, so reset needs no clearing pass. One request
// is handled at a time. Its scan starts at slot 0 (insert, remove, search) or at the
// iterator position (next) and stops at the first hit or at the high-water mark, one slot
// per cycle through the memory read port; rewind and unused codes scan no slots. A
// finished response waits in the output register while the next request is taken.
module key_value_slot_table_unit #(
   parameter int CAPACITY = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [kvst_pkg::FUNC_W-1:0]         req_func,
   input  logic signed [kvst_pkg::KEY_W-1:0]   req_key,
   input  logic signed [kvst_pkg::VALUE_W-1:0] req_value,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [kvst_pkg::SLOT_W-1:0]         rsp_slot,
   output logic [kvst_pkg::STAT_W-1:0]         rsp_status,
   output logic signed [kvst_pkg::KEY_W-1:0]   rsp_key_out,
   output logic signed [kvst_pkg::VALUE_W-1:0] rsp_value_out,
   output logic [kvst_pkg::COUNT_W-1:0]        rsp_live_count
);
   import kvst_pkg::*;

   localparam int AW = $clog2(CAPACITY);

   logic               idle;
   logic [AW-1:0]      rd_addr;
   logic [AW-1:0]      wr_addr;
   logic [KEY_W:0]     key_rdata;
   logic [KEY_W:0]     key_wdata;
   logic [VALUE_W-1:0] val_rdata;
   logic [VALUE_W-1:0] val_wdata;
   logic               key_we;
   logic               val_we;
   logic               res_valid;
   logic               res_ready;
   result_type         res;

   logic               rsp_valid_ff;
   result_type         rsp_ff;

   assign req_stall = !idle;

   // live bit and key per slot
   kvst_ram #(.WIDTH(KEY_W + 1), .DEPTH(CAPACITY)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (wr_addr),
      .wr_data (key_wdata),
      .rd_addr (rd_addr),
      .rd_data (key_rdata)
   );

   // value per slot
   kvst_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_value_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (wr_addr),
      .wr_data (val_wdata),
      .rd_addr (rd_addr),
      .rd_data (val_rdata)
   );

   kvst_engine #(.CAPACITY(CAPACITY)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (req_valid),
      .idle      (idle),
      .func      (req_func),
      .key       (req_key),
      .value     (req_value),
      .rd_addr   (rd_addr),
      .key_rdata (key_rdata),
      .val_rdata (val_rdata),
      .wr_addr   (wr_addr),
      .key_we    (key_we),
      .key_wdata (key_wdata),
      .val_we    (val_we),
      .val_wdata (val_wdata),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   // output register: loads when empty or when its beat leaves
   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
      if (res_ready && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slot       = rsp_ff.slot;
   assign rsp_status     = rsp_ff.status;
   assign rsp_key_out    = rsp_ff.key_out;
   assign rsp_value_out  = rsp_ff.value_out;
   assign rsp_live_count = rsp_ff.live_count;

endmodule
